// ----- rtl/core/laplacian_edge_threshold_top_macros.svh -----
// assertion macros used by the port-level checker of the edge detector
`ifndef LAPLACIAN_EDGE_THRESHOLD_TOP_MACROS_SVH
`define LAPLACIAN_EDGE_THRESHOLD_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define LE_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lap_edge_pkg.sv -----
// package: constants, register indexes and types of the laplacian edge detector
`default_nettype none

package lap_edge_pkg;

    // image limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // field widths
    localparam int PIX_W   = 8;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 11;
    localparam int THR_W   = 8;
    localparam int WID_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    // row counter saturates at the smaller of the height limit and the field range
    localparam logic [ROW_W-1:0] ROW_LIMIT =
        ROW_W'(((MAX_HEIGHT - 1) > 2047) ? 2047 : (MAX_HEIGHT - 1));

    // width clamp bounds
    localparam logic [WID_W-1:0] WIDTH_MIN = WID_W'(3);
    localparam logic [WID_W-1:0] WIDTH_MAX = WID_W'(MAX_WIDTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = CFG_IDX_W'(1);

    // configuration reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(100);
    localparam logic [WID_W-1:0] WIDTH_RST     = WID_W'(640);

    // one entry of the line store: pixels of the two rows above
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } t_line;

    // one result item
    typedef struct packed {
        logic             edge_res;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
    } t_result;

    // what the window stage hands to the output queue
    typedef struct packed {
        logic    busy;      // an item sits in the window stage
        logic    push;      // that item yields a result this cycle
        t_result res;
    } t_front_out;

endpackage

`default_nettype wire

// ----- rtl/core/lap_edge_ifs.sv -----
// channel interfaces: pixel input, result output and configuration writes
`default_nettype none

interface lap_edge_pix_if;
    import lap_edge_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             start_of_frame;
    modport source (output valid, pixel_value, start_of_frame, input ready);
    modport sink   (input valid, pixel_value, start_of_frame, output ready);
endinterface

interface lap_edge_res_if;
    import lap_edge_pkg::*;
    logic             valid;
    logic             ready;
    logic             edge_res;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    modport source (output valid, edge_res, out_col, out_row, input ready);
    modport sink   (input valid, edge_res, out_col, out_row, output ready);
endinterface

interface lap_edge_cfg_if;
    import lap_edge_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lap_edge_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module lap_edge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lap_edge_front.sv -----
// raster counters, line store read-modify-write, 3x3 window and edge decision
`default_nettype none

module lap_edge_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [lap_edge_pkg::PIX_W-1:0]  i_pixel,
    input  wire logic                            i_sof,
    input  wire logic [lap_edge_pkg::THR_W-1:0]  i_threshold,
    input  wire logic [lap_edge_pkg::WID_W-1:0]  i_width,
    output lap_edge_pkg::t_front_out             o_front
);
    import lap_edge_pkg::*;

    // raster position of the next pixel
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] col_now;
    logic [ROW_W-1:0] row_now;
    logic [WID_W-1:0] width_use;
    logic [WID_W-1:0] col_plus;

    // window stage
    logic             r_s1_vld;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_fwd_hit;
    t_line            r_fwd_data;
    t_line            ram_q;
    t_line            rd_line;
    t_line            wr_line;

    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] n_win [3][3];
    logic [PIX_W+1:0] center4;
    logic [PIX_W+1:0] nb_sum;
    logic [PIX_W+1:0] mag;
    logic [PIX_W+1:0] thr4;

    // position of the incoming pixel and the one after it
    always_comb begin
        col_now = i_sof ? '0 : r_col;
        row_now = i_sof ? '0 : r_row;
        if (i_width < WIDTH_MIN) begin
            width_use = WIDTH_MIN;
        end else if (i_width > WIDTH_MAX) begin
            width_use = WIDTH_MAX;
        end else begin
            width_use = i_width;
        end
        col_plus = {1'b0, col_now} + WID_W'(1);
        if (col_plus >= width_use) begin
            n_col = '0;
            n_row = (row_now < ROW_LIMIT) ? row_now + ROW_W'(1) : row_now;
        end else begin
            n_col = col_plus[COL_W-1:0];
            n_row = row_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // capture the request and note a write to the same entry at the read edge
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col   <= col_now;
            r_s1_row   <= row_now;
            r_s1_pix   <= i_pixel;
            r_fwd_hit  <= r_s1_vld && (r_s1_col == col_now);
            r_fwd_data <= wr_line;
        end
    end

    // line store: both rows above share one entry per column
    lap_edge_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col[ADDR_W-1:0]),
        .i_wdata (wr_line),
        .i_re    (i_accept),
        .i_raddr (col_now[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    // forwarded read data and the rows shifted down by one
    always_comb begin
        rd_line        = r_fwd_hit ? r_fwd_data : ram_q;
        wr_line.upper  = rd_line.middle;
        wr_line.middle = r_s1_pix;
    end

    // window shift
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = rd_line.upper;
        n_win[1][2] = rd_line.middle;
        n_win[2][2] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_s1_vld) begin
            r_win <= n_win;
        end
    end

    // laplacian magnitude against four times the threshold
    always_comb begin
        center4 = {n_win[1][1], 2'b00};
        nb_sum  = {2'b00, n_win[0][1]} + {2'b00, n_win[2][1]}
                + {2'b00, n_win[1][0]} + {2'b00, n_win[1][2]};
        mag     = (center4 >= nb_sum) ? center4 - nb_sum : nb_sum - center4;
        thr4    = {i_threshold, 2'b00};
    end

    // result of the window stage
    always_comb begin
        o_front.busy         = r_s1_vld;
        o_front.push         = r_s1_vld && (r_s1_row >= ROW_W'(2)) && (r_s1_col >= COL_W'(2));
        o_front.res.edge_res = mag > thr4;
        o_front.res.out_col  = r_s1_col - COL_W'(1);
        o_front.res.out_row  = r_s1_row - ROW_W'(1);
    end

endmodule

`default_nettype wire

// ----- rtl/core/lap_edge_oq.sv -----
// small result queue that decouples the window stage from the receiver
`default_nettype none

module lap_edge_oq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire lap_edge_pkg::t_result             i_data,
    input  wire logic                              i_pop,
    output logic                                   o_valid,
    output lap_edge_pkg::t_result                  o_data,
    output logic [lap_edge_pkg::OQ_CNT_W-1:0]      o_count
);
    import lap_edge_pkg::*;

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_head;
    logic [OQ_PTR_W-1:0] r_tail;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_head];
    assign o_count = r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + OQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_head <= r_head + OQ_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + OQ_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - OQ_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/laplacian_edge_threshold_top.sv -----
// Laplacian edge detector with threshold for a raster stream of 8-bit gray pixels.
//
// Channels: i_pix takes one pixel per request (pixel_value, start_of_frame, which
// puts that pixel at row 0, column 0). o_res gives one request per interior pixel
// (edge_res, out_col, out_row of the judged center, one row and column behind the
// newest pixel). i_cfg writes threshold (index 0) and image_width (index 1); it is
// always ready. The user must write it only while the block is idle; the block
// itself does not enforce this. A result passes the window stage and the result
// queue before it is shown on o_res. Throughput: one pixel per clock while i_pix is
// ready, set by the single line store ram, read at the accept edge and written back
// in the following cycle, with a forward path for a write to the entry being read.
// Stall: results wait in a four-entry queue; i_pix stays ready while the queued
// results plus any item in the window stage number at most two, so a receiver that
// takes one result per cycle never throttles the stream.
// Reset: synchronous, active low; counters start at row 0, column 0, threshold
// 100, image_width 640. The line store needs no clearing pass.
`default_nettype none

module laplacian_edge_threshold_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lap_edge_pix_if.sink  i_pix,
    lap_edge_res_if.source o_res,
    lap_edge_cfg_if.sink  i_cfg
);
    import lap_edge_pkg::*;

    logic [THR_W-1:0]    r_threshold;
    logic [WID_W-1:0]    r_width;
    logic                pix_accept;
    t_front_out          front;
    t_result             head;
    logic                oq_valid;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [OQ_CNT_W-1:0] pending;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_width     <= WIDTH_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_THRESHOLD:   r_threshold <= i_cfg.data[THR_W-1:0];
                REG_IMAGE_WIDTH: r_width     <= i_cfg.data[WID_W-1:0];
                default:         r_width     <= r_width;
            endcase
        end
    end

    // input flow control by queue room
    assign pending     = oq_count + OQ_CNT_W'(front.busy);
    assign i_pix.ready = (pending <= OQ_CNT_W'(2));
    assign pix_accept  = i_pix.valid && i_pix.ready;

    lap_edge_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (pix_accept),
        .i_pixel     (i_pix.pixel_value),
        .i_sof       (i_pix.start_of_frame),
        .i_threshold (r_threshold),
        .i_width     (r_width),
        .o_front     (front)
    );

    lap_edge_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front.push),
        .i_data  (front.res),
        .i_pop   (o_res.ready),
        .o_valid (oq_valid),
        .o_data  (head),
        .o_count (oq_count)
    );

    // result channel
    assign o_res.valid    = oq_valid;
    assign o_res.edge_res = head.edge_res;
    assign o_res.out_col  = head.out_col;
    assign o_res.out_row  = head.out_row;

endmodule

`default_nettype wire

// ----- rtl/core/lap_edge_chk.sv -----
// port-level checker for the edge detector and its bind to the top level
`default_nettype none

`include "laplacian_edge_threshold_top_macros.svh"

module lap_edge_chk (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_res_valid,
    input  wire logic                            i_res_ready,
    input  wire logic                            i_edge_res,
    input  wire logic [lap_edge_pkg::COL_W-1:0]  i_out_col,
    input  wire logic [lap_edge_pkg::ROW_W-1:0]  i_out_row
);
    import lap_edge_pkg::*;

    // a result held back by the receiver stays unchanged
    `LE_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_edge_res) && $stable(i_out_col) && $stable(i_out_row), "stalled result changed")

    // only interior pixels are judged
    `LE_ASSERT_IMP(a_interior, i_clk, i_rst_n, i_res_valid, (i_out_col != '0) && (i_out_row != '0) && (i_out_col != COL_W'(MAX_WIDTH - 1)), "border pixel reported")

    // nothing is shown right after reset
    `LE_ASSERT_NXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_res_valid, "result valid after reset")

endmodule

bind laplacian_edge_threshold_top lap_edge_chk u_lap_edge_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_edge_res  (o_res.edge_res),
    .i_out_col   (o_res.out_col),
    .i_out_row   (o_res.out_row)
);

`default_nettype wire

// ----- tb/lap_edge_checker.sv -----
// checker for the edge detector: predicts each verdict from the accepted pixels and compares
`timescale 1ns / 1ps

module lap_edge_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lap_edge_pix_if i_pix,
    lap_edge_res_if i_res,
    lap_edge_cfg_if i_cfg,
    output int      o_fail_count,
    output int      o_pending
);
    import lap_edge_pkg::*;

    // keep the log short when the block is badly off
    localparam int PRINT_CAP = 40;

    // own copy of the detector state
    logic [PIX_W-1:0] upper_row_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_row_mem [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int               col_pos;
    int               row_pos;
    logic [THR_W-1:0] thr_reg;
    logic [WID_W-1:0] width_reg;

    // verdicts still owed by the block, oldest first
    t_result expected_verdicts [$];
    t_result taken_verdict;
    int      fail_total = 0;

    task automatic report_mismatch(input string what);
        if (fail_total < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fail_total++;
    endtask

    task automatic clear_state();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row_mem[i]  = '0;
            middle_row_mem[i] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win[r][c] = '0;
            end
        end
        col_pos   = 0;
        row_pos   = 0;
        thr_reg   = THRESHOLD_RST;
        width_reg = WIDTH_RST;
        expected_verdicts.delete();
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_THRESHOLD: begin
                thr_reg = data[THR_W-1:0];
            end
            REG_IMAGE_WIDTH: begin
                width_reg = data[WID_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // slide the window by one pixel and judge the center once it is interior
    task automatic judge_pixel(input logic [PIX_W-1:0] pixel, input logic sof);
        int      w;
        int      neighbors;
        int      lap;
        t_result verdict;
        w = int'(width_reg);
        if (w < int'(WIDTH_MIN)) w = int'(WIDTH_MIN);
        if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);
        if (sof) begin
            col_pos = 0;
            row_pos = 0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 2; c++) begin
                win[r][c] = win[r][c+1];
            end
        end
        win[0][2] = upper_row_mem[col_pos];
        win[1][2] = middle_row_mem[col_pos];
        win[2][2] = pixel;
        upper_row_mem[col_pos]  = middle_row_mem[col_pos];
        middle_row_mem[col_pos] = pixel;

        if (row_pos >= 2 && col_pos >= 2) begin
            neighbors = int'(win[0][1]) + int'(win[2][1]) + int'(win[1][0]) + int'(win[1][2]);
            lap = 4 * int'(win[1][1]) - neighbors;
            if (lap < 0) lap = -lap;
            verdict.edge_res = (lap > 4 * int'(thr_reg));
            verdict.out_col  = COL_W'(col_pos - 1);
            verdict.out_row  = ROW_W'(row_pos - 1);
            expected_verdicts.push_back(verdict);
        end

        // column wraps at the width in use, row saturates at its limit
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos < int'(ROW_LIMIT)) row_pos++;
        end else begin
            col_pos++;
        end
    endtask

    task automatic check_verdict(input t_result got);
        t_result want;
        if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("result with none expected: edge %0b col %0d row %0d",
                                      got.edge_res, got.out_col, got.out_row));
            return;
        end
        want = expected_verdicts.pop_front();
        if (got.edge_res !== want.edge_res) begin
            report_mismatch($sformatf("edge_res %0b, expected %0b at col %0d row %0d",
                                      got.edge_res, want.edge_res, want.out_col, want.out_row));
        end
        if (got.out_col !== want.out_col) begin
            report_mismatch($sformatf("out_col %0d, expected %0d (row %0d)",
                                      got.out_col, want.out_col, want.out_row));
        end
        if (got.out_row !== want.out_row) begin
            report_mismatch($sformatf("out_row %0d, expected %0d (col %0d)",
                                      got.out_row, want.out_row, want.out_col));
        end
    endtask

    // results first, then register writes, then the new pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_res.valid && i_res.ready) begin
                taken_verdict.edge_res = i_res.edge_res;
                taken_verdict.out_col  = i_res.out_col;
                taken_verdict.out_row  = i_res.out_row;
                check_verdict(taken_verdict);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                apply_reg_write(i_cfg.index, i_cfg.data);
            end
            if (i_pix.valid && i_pix.ready) begin
                judge_pixel(i_pix.pixel_value, i_pix.start_of_frame);
            end
        end
        o_pending    <= expected_verdicts.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/tb.sv -----
// testbench top: drives pixels, register writes and result back-pressure, and gives the verdict
`timescale 1ns / 1ps

module tb;
    import lap_edge_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 6;
    localparam int STUCK_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_TARGET = 760;
    localparam int TAIL_ROWS     = 40;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    // hand-made frames: a bright spot, a bright-dark-bright row below it, then a dark hole after a new frame
    localparam int PROBE_SOF_AT = 12;
    localparam logic [PIX_W-1:0] PROBE_PIX [21] = '{
        8'd0,   8'd0,   8'd0,
        8'd0,   8'd255, 8'd0,
        8'd0,   8'd0,   8'd0,
        8'd255, 8'd0,   8'd255,
        8'd255, 8'd255, 8'd255,
        8'd255, 8'd0,   8'd255,
        8'd255, 8'd255, 8'd255
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;

    // stimulus knobs shared between processes
    bit   send_gaps;
    bit   sink_gaps;
    bit   hold_request;
    int   written_span;
    int   flat_level;

    lap_edge_pix_if pix_ch ();
    lap_edge_res_if res_ch ();
    lap_edge_cfg_if cfg_ch ();

    laplacian_edge_threshold_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    lap_edge_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pixels: mostly noise, extremes and flat patches near the phase level
    function automatic logic [PIX_W-1:0] pick_pixel();
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom_range(0, 255);
            2: v = $urandom_range(0, 1) ? 255 : 0;
            3, 4: v = flat_level;
            default: v = flat_level + int'($urandom_range(0, 6)) - 3;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    // threshold writes carry junk in the unused upper bits
    function automatic logic [CFG_DAT_W-1:0] pick_threshold();
        logic [THR_W-1:0] thr;
        case ($urandom_range(0, 7))
            0: thr = 8'd0;
            1: thr = 8'd255;
            2: thr = 8'd254;
            default: thr = THR_W'($urandom_range(0, 255));
        endcase
        return {4'($urandom_range(0, 15)), thr};
    endfunction

    // mostly narrow images so rows finish quickly
    function automatic logic [CFG_DAT_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return CFG_DAT_W'($urandom_range(0, 2));
            1: return CFG_DAT_W'($urandom_range(13, 40));
            default: return CFG_DAT_W'($urandom_range(3, 12));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] value, input bit sof);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        pix_ch.valid          <= 1'b1;
        pix_ch.pixel_value    <= value;
        pix_ch.start_of_frame <= sof;
        @(posedge i_clk);
        while (pix_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    // a run of pixels, optionally opening a frame, with a rare stray frame start
    task automatic send_stream(input int count, input bit sof_first, input bit stray_sof);
        bit sof;
        for (int i = 0; i < count; i++) begin
            sof = (i == 0 && sof_first) || (stray_sof && $urandom_range(0, 299) == 0);
            send_pixel(pick_pixel(), sof);
        end
    endtask

    // register write request; valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    // stop pixels, wait for every owed result, then let the pipeline drain
    task automatic settle();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reprogram(input logic [CFG_DAT_W-1:0] thr_data,
                             input logic [CFG_DAT_W-1:0] wid_data, output int w_eff);
        settle();
        write_reg(REG_THRESHOLD, thr_data);
        write_reg(REG_IMAGE_WIDTH, wid_data);
        cfg_ch.valid <= 1'b0;
        w_eff = int'(wid_data);
        if (w_eff < int'(WIDTH_MIN)) w_eff = int'(WIDTH_MIN);
        if (w_eff > int'(WIDTH_MAX)) w_eff = int'(WIDTH_MAX);
        flat_level = $urandom_range(0, 255);
    endtask

    // result side: random hold-offs, plus one long hold on request
    initial begin : result_sink
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // no request on any channel for too long ends the run
    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int w_eff;
        int count;
        int random_sent;
        bit sof_first;
        pix_ch.valid          <= 1'b0;
        pix_ch.pixel_value    <= '0;
        pix_ch.start_of_frame <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_THRESHOLD;
        cfg_ch.data           <= '0;
        i_rst_n               <= 1'b0;
        send_gaps    = 1'b0;
        sink_gaps    = 1'b0;
        hold_request = 1'b0;
        written_span = 0;
        flat_level   = 128;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unmapped indexes, masked threshold, width clamped up, no frame start at the first pixel
        write_reg(REG_SPARE_LO, 12'h5A5);
        write_reg(REG_THRESHOLD, 12'hFFE);
        write_reg(REG_SPARE_HI, 12'hA5A);
        write_reg(REG_IMAGE_WIDTH, 12'h000);
        cfg_ch.valid <= 1'b0;
        for (int i = 0; i < 21; i++) begin
            send_pixel(PROBE_PIX[i], i == PROBE_SOF_AT);
        end
        written_span = 3;

        // long result hold while pixels keep coming, so the input backs up
        send_gaps = 1'b0;
        sink_gaps = 1'b1;
        reprogram(pick_threshold(), 12'd6, w_eff);
        hold_request = 1'b1;
        send_stream(10 * w_eff, 1'b1, 1'b0);
        written_span = w_eff;

        // width cut while the column already sits past the new width
        send_gaps = 1'b1;
        reprogram(pick_threshold(), 12'd10, w_eff);
        send_stream(3 * w_eff + 7, 1'b1, 1'b0);
        written_span = w_eff;
        reprogram(pick_threshold(), 12'd4, w_eff);
        send_stream(4 * w_eff + 1, 1'b0, 1'b0);

        // random frames; a wider image always opens with a frame start
        random_sent = 0;
        while (random_sent < RANDOM_TARGET) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            reprogram(pick_threshold(), pick_width(), w_eff);
            count = $urandom_range(3, 8) * w_eff + $urandom_range(0, w_eff - 1);
            sof_first = (w_eff > written_span) || ($urandom_range(0, 1) == 1);
            send_stream(count, sof_first, 1'b1);
            if (w_eff > written_span) written_span = w_eff;
            random_sent += count;
        end

        // last part without idling: a run of rows on the narrowest image
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        reprogram(pick_threshold(), 12'd1, w_eff);
        send_stream(TAIL_ROWS * w_eff, 1'b1, 1'b0);

        // drain and verdict
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
